/* design/lobm_pkg.sv */
// lobm_pkg: shared constants, codes and types of the limit order book matcher.
// Used by every module of the design; depends on nothing.
package lobm_pkg;

    localparam int PRICE_LEVELS  = 1024;
    localparam int ORDER_SLOTS   = 64;
    localparam int ORDER_ID_BITS = 16;

    localparam int PRICE_W = $clog2(PRICE_LEVELS);
    localparam int SIDX_W  = $clog2(ORDER_SLOTS);
    localparam int SLOT_W  = 7;
    localparam int QTY_W   = 32;
    localparam int TS_W    = 64;
    localparam int HINT_W  = 11;
    localparam int FILL_W  = 6;
    localparam int CNT_W   = $clog2(ORDER_SLOTS + 1);
    localparam int LKEY_W  = PRICE_W + 1;
    localparam int CLR_W   = (ORDER_ID_BITS > LKEY_W) ? ORDER_ID_BITS : LKEY_W;

    localparam logic [SLOT_W-1:0]  NIL        = '1;
    localparam logic [PRICE_W-1:0] LAST_PRICE = PRICE_W'(PRICE_LEVELS - 1);
    localparam logic [CLR_W-1:0]   CLR_LAST   = '1;

    localparam logic [1:0] CMD_LIMIT      = 2'd0;
    localparam logic [1:0] CMD_MARKET     = 2'd1;
    localparam logic [1:0] CMD_CANCEL     = 2'd2;
    localparam logic [1:0] CMD_CANCEL_ALT = 2'd3;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [ORDER_ID_BITS-1:0] id;
        logic [PRICE_W-1:0]       price;
        logic [QTY_W-1:0]         remaining;
        logic                     side;
        logic [SLOT_W-1:0]        next;
        logic [SLOT_W-1:0]        prev;
    } t_slot;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_level;

    typedef struct packed {
        logic              take;
        logic              release_slot;
        logic [SIDX_W-1:0] idx;
    } t_pool_cmd;

    typedef struct packed {
        logic              any_free;
        logic [SIDX_W-1:0] free_idx;
        logic [CNT_W-1:0]  resting;
    } t_pool_stat;

endpackage

/* design/lobm_slot_pool.sv */
// lobm_slot_pool: free map of the order slots, first-free search and resting count.
// Depends on lobm_pkg.
module lobm_slot_pool (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lobm_pkg::t_pool_cmd   i_cmd,
    output lobm_pkg::t_pool_stat  o_stat
);

    logic [lobm_pkg::ORDER_SLOTS-1:0] r_free;
    logic [lobm_pkg::CNT_W-1:0]       r_resting;
    logic [lobm_pkg::SIDX_W-1:0]      first_idx;

    always_comb begin
        first_idx = '0;
        for (int i = lobm_pkg::ORDER_SLOTS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                first_idx = lobm_pkg::SIDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '1;
            r_resting <= '0;
        end else if (i_cmd.take) begin
            r_free[i_cmd.idx] <= 1'b0;
            r_resting         <= r_resting + 1'b1;
        end else if (i_cmd.release_slot) begin
            r_free[i_cmd.idx] <= 1'b1;
            r_resting         <= r_resting - 1'b1;
        end
    end

    assign o_stat.any_free = |r_free;
    assign o_stat.free_idx = first_idx;
    assign o_stat.resting  = r_resting;

endmodule

/* design/lobm_engine.sv */
// lobm_engine: sequencer over the slot, price level and id map memories.
// Matches, rests and cancels orders and drives the result register. Depends on lobm_pkg.
module lobm_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [lobm_pkg::ORDER_ID_BITS-1:0]   i_order_id,
    input  logic                                 i_side,
    input  logic [lobm_pkg::PRICE_W-1:0]         i_price,
    input  logic [lobm_pkg::QTY_W-1:0]           i_quantity,
    input  logic [lobm_pkg::TS_W-1:0]            i_timestamp,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_last,
    output logic [lobm_pkg::ORDER_ID_BITS-1:0]   o_buy_id,
    output logic [lobm_pkg::ORDER_ID_BITS-1:0]   o_sell_id,
    output logic [lobm_pkg::PRICE_W-1:0]         o_trade_price,
    output logic [lobm_pkg::QTY_W-1:0]           o_trade_quantity,
    output logic [lobm_pkg::TS_W-1:0]            o_trade_time,
    output logic                                 o_status,
    output logic [lobm_pkg::FILL_W-1:0]          o_fill_count,
    output logic signed [lobm_pkg::HINT_W-1:0]   o_best_bid,
    output logic signed [lobm_pkg::HINT_W-1:0]   o_best_ask,
    output logic [lobm_pkg::CNT_W-1:0]           o_resting_count,
    output lobm_pkg::t_pool_cmd                  o_pool_cmd,
    input  lobm_pkg::t_pool_stat                 i_pool_stat
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_C_ID, S_C_IDW, S_C_SL, S_C_LV, S_UNL1, S_UNL2,
        S_M_CHK, S_M_LV, S_M_SL, S_M_ID, S_M_IDW, S_REST, S_R_LV, S_R_LNK,
        S_RSB, S_RSB_W, S_RSA, S_RSA_W, S_FIN
    } t_state;

    // memories
    lobm_pkg::t_slot                   r_slot_mem [lobm_pkg::ORDER_SLOTS];
    lobm_pkg::t_level                  r_lvl_mem  [2 * lobm_pkg::PRICE_LEVELS];
    logic [lobm_pkg::SLOT_W-1:0]       r_idm_mem  [2 ** lobm_pkg::ORDER_ID_BITS];
    lobm_pkg::t_slot                   r_slot_rd;
    lobm_pkg::t_level                  r_lvl_rd;
    logic [lobm_pkg::SLOT_W-1:0]       r_idm_rd;

    logic                              slot_rd_en;
    logic [lobm_pkg::SIDX_W-1:0]       slot_rd_addr;
    logic                              slot_we_all;
    logic                              slot_we_next;
    logic                              slot_we_prev;
    logic                              slot_we_rem;
    logic [lobm_pkg::SIDX_W-1:0]       slot_wr_addr;
    lobm_pkg::t_slot                   slot_wr_data;
    logic                              lvl_rd_en;
    logic [lobm_pkg::LKEY_W-1:0]       lvl_rd_addr;
    logic                              lvl_we;
    logic [lobm_pkg::LKEY_W-1:0]       lvl_wr_addr;
    lobm_pkg::t_level                  lvl_wr_data;
    logic                              idm_rd_en;
    logic [lobm_pkg::ORDER_ID_BITS-1:0] idm_rd_addr;
    logic                              idm_we;
    logic [lobm_pkg::ORDER_ID_BITS-1:0] idm_wr_addr;
    logic [lobm_pkg::SLOT_W-1:0]       idm_wr_data;

    // sequencer registers
    t_state                             r_state;
    logic [lobm_pkg::CLR_W-1:0]         r_clr;
    logic                               r_limit;
    logic                               r_cancel;
    logic [lobm_pkg::ORDER_ID_BITS-1:0] r_id;
    logic                               r_side;
    logic [lobm_pkg::PRICE_W-1:0]       r_price;
    logic [lobm_pkg::QTY_W-1:0]         r_rem;
    logic [lobm_pkg::TS_W-1:0]          r_ts;
    logic [lobm_pkg::SIDX_W-1:0]        r_s;
    logic                               r_status;
    logic [lobm_pkg::FILL_W-1:0]        r_fills;
    logic signed [lobm_pkg::HINT_W-1:0] r_bid;
    logic signed [lobm_pkg::HINT_W-1:0] r_ask;
    logic [lobm_pkg::SLOT_W-1:0]        r_cur;
    lobm_pkg::t_level                   r_lv;
    lobm_pkg::t_slot                    r_sl;
    logic [lobm_pkg::LKEY_W-1:0]        r_lkey;
    logic [lobm_pkg::PRICE_W-1:0]       r_lp;

    logic                               r_o_valid;
    logic                               r_o_last;
    logic [lobm_pkg::ORDER_ID_BITS-1:0] r_o_buy;
    logic [lobm_pkg::ORDER_ID_BITS-1:0] r_o_sell;
    logic [lobm_pkg::PRICE_W-1:0]       r_o_price;
    logic [lobm_pkg::QTY_W-1:0]         r_o_qty;
    logic [lobm_pkg::TS_W-1:0]          r_o_time;
    logic                               r_o_status;
    logic [lobm_pkg::FILL_W-1:0]        r_o_fills;
    logic signed [lobm_pkg::HINT_W-1:0] r_o_bid;
    logic signed [lobm_pkg::HINT_W-1:0] r_o_ask;
    logic [lobm_pkg::CNT_W-1:0]         r_o_rest;

    logic                               out_free;
    logic                               out_load;
    logic signed [lobm_pkg::HINT_W-1:0] lp;
    logic                               no_cross;
    logic [lobm_pkg::QTY_W-1:0]         trade_amt;
    logic [lobm_pkg::QTY_W-1:0]         left_qty;
    logic                               price_below_ask;
    logic                               price_above_bid;

    assign out_free = !r_o_valid || i_out_ready;
    assign out_load = out_free && (r_state == S_M_SL || r_state == S_FIN);
    assign lp       = r_side ? r_bid : r_ask;
    assign no_cross = r_limit && (r_side ? (r_price > lp[lobm_pkg::PRICE_W-1:0])
                                         : (r_price < lp[lobm_pkg::PRICE_W-1:0]));
    assign trade_amt = (r_rem < r_slot_rd.remaining) ? r_rem : r_slot_rd.remaining;
    assign left_qty  = r_slot_rd.remaining - trade_amt;
    assign price_below_ask = r_ask[lobm_pkg::HINT_W-1] ||
                             (r_price < r_ask[lobm_pkg::PRICE_W-1:0]);
    assign price_above_bid = r_bid[lobm_pkg::HINT_W-1] ||
                             (r_price > r_bid[lobm_pkg::PRICE_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (slot_we_all) begin
            r_slot_mem[slot_wr_addr] <= slot_wr_data;
        end else begin
            if (slot_we_next) r_slot_mem[slot_wr_addr].next <= slot_wr_data.next;
            if (slot_we_prev) r_slot_mem[slot_wr_addr].prev <= slot_wr_data.prev;
            if (slot_we_rem) r_slot_mem[slot_wr_addr].remaining <= slot_wr_data.remaining;
        end
        if (slot_rd_en) r_slot_rd <= r_slot_mem[slot_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) r_lvl_mem[lvl_wr_addr] <= lvl_wr_data;
        if (lvl_rd_en) r_lvl_rd <= r_lvl_mem[lvl_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (idm_we) r_idm_mem[idm_wr_addr] <= idm_wr_data;
        if (idm_rd_en) r_idm_rd <= r_idm_mem[idm_rd_addr];
    end

    always_comb begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = '0;
        slot_we_all  = 1'b0;
        slot_we_next = 1'b0;
        slot_we_prev = 1'b0;
        slot_we_rem  = 1'b0;
        slot_wr_addr = '0;
        slot_wr_data = '0;
        lvl_rd_en    = 1'b0;
        lvl_rd_addr  = '0;
        lvl_we       = 1'b0;
        lvl_wr_addr  = r_lkey;
        lvl_wr_data  = '0;
        idm_rd_en    = 1'b0;
        idm_rd_addr  = r_id;
        idm_we       = 1'b0;
        idm_wr_addr  = r_id;
        idm_wr_data  = lobm_pkg::NIL;
        o_pool_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                idm_we      = 1'b1;
                idm_wr_addr = r_clr[lobm_pkg::ORDER_ID_BITS-1:0];
                lvl_we      = 1'b1;
                lvl_wr_addr = r_clr[lobm_pkg::LKEY_W-1:0];
                lvl_wr_data = '{head: lobm_pkg::NIL, tail: lobm_pkg::NIL};
            end
            S_C_ID: begin
                idm_rd_en = 1'b1;
            end
            S_C_IDW: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = r_idm_rd[lobm_pkg::SIDX_W-1:0];
            end
            S_C_SL: begin
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = {r_slot_rd.side, r_slot_rd.price};
            end
            S_C_LV: begin
                idm_we                  = 1'b1;
                o_pool_cmd.release_slot = 1'b1;
                o_pool_cmd.idx          = r_cur[lobm_pkg::SIDX_W-1:0];
            end
            S_UNL1: begin
                lvl_we           = 1'b1;
                lvl_wr_data.head = (r_sl.prev == lobm_pkg::NIL) ? r_sl.next : r_lv.head;
                lvl_wr_data.tail = (r_sl.next == lobm_pkg::NIL) ? r_sl.prev : r_lv.tail;
                slot_we_next      = (r_sl.prev != lobm_pkg::NIL);
                slot_wr_addr      = r_sl.prev[lobm_pkg::SIDX_W-1:0];
                slot_wr_data.next = r_sl.next;
            end
            S_UNL2: begin
                slot_we_prev      = (r_sl.next != lobm_pkg::NIL);
                slot_wr_addr      = r_sl.next[lobm_pkg::SIDX_W-1:0];
                slot_wr_data.prev = r_sl.prev;
            end
            S_M_CHK: begin
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = {~r_side, lp[lobm_pkg::PRICE_W-1:0]};
            end
            S_M_LV: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = r_lvl_rd.head[lobm_pkg::SIDX_W-1:0];
            end
            S_M_SL: begin
                if (out_free) begin
                    slot_we_rem            = 1'b1;
                    slot_wr_addr           = r_cur[lobm_pkg::SIDX_W-1:0];
                    slot_wr_data.remaining = left_qty;
                    if (left_qty == '0) begin
                        o_pool_cmd.release_slot = 1'b1;
                        o_pool_cmd.idx          = r_cur[lobm_pkg::SIDX_W-1:0];
                    end
                end
            end
            S_M_ID: begin
                idm_rd_en   = 1'b1;
                idm_rd_addr = r_sl.id;
            end
            S_M_IDW: begin
                idm_wr_addr = r_sl.id;
                idm_we      = (r_idm_rd == r_cur);
            end
            S_REST: begin
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = {r_side, r_price};
            end
            S_R_LV: begin
                slot_we_all  = 1'b1;
                slot_wr_addr = r_s;
                slot_wr_data = '{id: r_id, price: r_price, remaining: r_rem, side: r_side,
                                 next: lobm_pkg::NIL, prev: r_lvl_rd.tail};
                lvl_we           = 1'b1;
                lvl_wr_addr      = {r_side, r_price};
                lvl_wr_data.head = (r_lvl_rd.tail == lobm_pkg::NIL) ?
                                   {1'b0, r_s} : r_lvl_rd.head;
                lvl_wr_data.tail = {1'b0, r_s};
                idm_we           = 1'b1;
                idm_wr_data      = {1'b0, r_s};
                o_pool_cmd.take  = 1'b1;
                o_pool_cmd.idx   = r_s;
            end
            S_R_LNK: begin
                slot_we_next      = (r_lv.tail != lobm_pkg::NIL);
                slot_wr_addr      = r_lv.tail[lobm_pkg::SIDX_W-1:0];
                slot_wr_data.next = {1'b0, r_s};
            end
            S_RSB: begin
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = {lobm_pkg::SIDE_BUY, r_bid[lobm_pkg::PRICE_W-1:0]};
            end
            S_RSA: begin
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = {lobm_pkg::SIDE_SELL, r_ask[lobm_pkg::PRICE_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            r_bid     <= '1;
            r_ask     <= '1;
        end else begin
            if (out_load) r_o_valid <= 1'b1;
            else if (i_out_ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == lobm_pkg::CLR_LAST) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_id     <= i_order_id;
                        r_side   <= i_side;
                        r_price  <= (i_price > lobm_pkg::LAST_PRICE) ?
                                    lobm_pkg::LAST_PRICE : i_price;
                        r_rem    <= i_quantity;
                        r_ts     <= i_timestamp;
                        r_s      <= i_pool_stat.free_idx;
                        r_status <= 1'b0;
                        r_fills  <= '0;
                        r_limit  <= (i_cmd == lobm_pkg::CMD_LIMIT);
                        r_cancel <= 1'b0;
                        if (!i_pool_stat.any_free) begin
                            r_status <= 1'b1;
                            r_state  <= S_RSB;
                        end else begin
                            unique case (i_cmd) inside
                                lobm_pkg::CMD_LIMIT, lobm_pkg::CMD_MARKET: begin
                                    r_state <= S_M_CHK;
                                end
                                lobm_pkg::CMD_CANCEL, lobm_pkg::CMD_CANCEL_ALT: begin
                                    r_cancel <= 1'b1;
                                    r_state  <= S_C_ID;
                                end
                            endcase
                        end
                    end
                end
                S_C_ID: r_state <= S_C_IDW;
                S_C_IDW: begin
                    r_cur <= r_idm_rd;
                    if (r_idm_rd == lobm_pkg::NIL) begin
                        r_status <= 1'b1;
                        r_state  <= S_RSB;
                    end else begin
                        r_state <= S_C_SL;
                    end
                end
                S_C_SL: begin
                    r_sl    <= r_slot_rd;
                    r_lkey  <= {r_slot_rd.side, r_slot_rd.price};
                    r_state <= S_C_LV;
                end
                S_C_LV: begin
                    r_lv    <= r_lvl_rd;
                    r_state <= S_UNL1;
                end
                S_UNL1: r_state <= S_UNL2;
                S_UNL2: r_state <= r_cancel ? S_RSB : S_M_ID;
                S_M_CHK: begin
                    if (r_rem == '0 || lp[lobm_pkg::HINT_W-1] || no_cross) begin
                        r_state <= S_REST;
                    end else begin
                        r_lp    <= lp[lobm_pkg::PRICE_W-1:0];
                        r_lkey  <= {~r_side, lp[lobm_pkg::PRICE_W-1:0]};
                        r_state <= S_M_LV;
                    end
                end
                S_M_LV: begin
                    r_lv <= r_lvl_rd;
                    if (r_lvl_rd.head == lobm_pkg::NIL) begin
                        if (r_side) begin
                            r_bid <= (r_lp == '0) ? '1 :
                                     $signed({1'b0, r_lp - 1'b1});
                        end else begin
                            r_ask <= (r_lp == lobm_pkg::LAST_PRICE) ? '1 :
                                     $signed({1'b0, r_lp + 1'b1});
                        end
                        r_state <= S_M_CHK;
                    end else begin
                        r_cur   <= r_lvl_rd.head;
                        r_state <= S_M_SL;
                    end
                end
                S_M_SL: begin
                    if (out_free) begin
                        r_o_last   <= 1'b0;
                        r_o_buy    <= r_side ? r_slot_rd.id : r_id;
                        r_o_sell   <= r_side ? r_id : r_slot_rd.id;
                        r_o_price  <= r_lp;
                        r_o_qty    <= trade_amt;
                        r_o_time   <= r_ts;
                        r_o_status <= 1'b0;
                        r_o_fills  <= '0;
                        r_o_bid    <= '0;
                        r_o_ask    <= '0;
                        r_o_rest   <= '0;
                        r_rem      <= r_rem - trade_amt;
                        r_fills    <= r_fills + 1'b1;
                        r_sl       <= r_slot_rd;
                        r_state    <= (left_qty == '0) ? S_UNL1 : S_M_CHK;
                    end
                end
                S_M_ID: r_state <= S_M_IDW;
                S_M_IDW: r_state <= S_M_CHK;
                S_REST: r_state <= (r_limit && r_rem != '0) ? S_R_LV : S_RSB;
                S_R_LV: begin
                    r_lv <= r_lvl_rd;
                    if (r_side) begin
                        if (price_below_ask) r_ask <= $signed({1'b0, r_price});
                    end else begin
                        if (price_above_bid) r_bid <= $signed({1'b0, r_price});
                    end
                    r_state <= S_R_LNK;
                end
                S_R_LNK: r_state <= S_RSB;
                S_RSB: r_state <= r_bid[lobm_pkg::HINT_W-1] ? S_RSA : S_RSB_W;
                S_RSB_W: begin
                    if (r_lvl_rd.head != lobm_pkg::NIL) begin
                        r_state <= S_RSA;
                    end else begin
                        r_bid   <= r_bid - 1'b1;
                        r_state <= (r_bid == '0) ? S_RSA : S_RSB;
                    end
                end
                S_RSA: r_state <= r_ask[lobm_pkg::HINT_W-1] ? S_FIN : S_RSA_W;
                S_RSA_W: begin
                    if (r_lvl_rd.head != lobm_pkg::NIL) begin
                        r_state <= S_FIN;
                    end else if (r_ask[lobm_pkg::PRICE_W-1:0] == lobm_pkg::LAST_PRICE) begin
                        r_ask   <= '1;
                        r_state <= S_FIN;
                    end else begin
                        r_ask   <= r_ask + 1'b1;
                        r_state <= S_RSA;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_last   <= 1'b1;
                        r_o_buy    <= '0;
                        r_o_sell   <= '0;
                        r_o_price  <= '0;
                        r_o_qty    <= '0;
                        r_o_time   <= '0;
                        r_o_status <= r_status;
                        r_o_fills  <= r_fills;
                        r_o_bid    <= r_bid;
                        r_o_ask    <= r_ask;
                        r_o_rest   <= i_pool_stat.resting;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_last           = r_o_last;
    assign o_buy_id         = r_o_buy;
    assign o_sell_id        = r_o_sell;
    assign o_trade_price    = r_o_price;
    assign o_trade_quantity = r_o_qty;
    assign o_trade_time     = r_o_time;
    assign o_status         = r_o_status;
    assign o_fill_count     = r_o_fills;
    assign o_best_bid       = r_o_bid;
    assign o_best_ask       = r_o_ask;
    assign o_resting_count  = r_o_rest;

endmodule

/* design/limit_order_book_matcher_unit.sv */
// Price-time priority order book: one transaction in, its trades and a final status out.
// After reset the id map and both level tables are swept to empty, during which no order is
// taken. Orders then go through one at a time: a cancel finds its order through the id map and
// unlinks it (an unknown id ends the search early); a match walks empty levels and fills resting
// orders, removing each one that is filled in full; an order that stops matching rests its
// remainder if it is a limit order. Every transaction ends with a rescan of both best prices
// (skipped for a side with no price, else level by level) and the final status item. A result
// that waits on the receiver holds the sequencer until it is taken.
// Depends on lobm_pkg, lobm_slot_pool and lobm_engine.
module limit_order_book_matcher_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [lobm_pkg::ORDER_ID_BITS-1:0]   i_order_id,
    input  logic                                 i_side,
    input  logic [lobm_pkg::PRICE_W-1:0]         i_price,
    input  logic [lobm_pkg::QTY_W-1:0]           i_quantity,
    input  logic [lobm_pkg::TS_W-1:0]            i_timestamp,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_last,
    output logic [lobm_pkg::ORDER_ID_BITS-1:0]   o_buy_id,
    output logic [lobm_pkg::ORDER_ID_BITS-1:0]   o_sell_id,
    output logic [lobm_pkg::PRICE_W-1:0]         o_trade_price,
    output logic [lobm_pkg::QTY_W-1:0]           o_trade_quantity,
    output logic [lobm_pkg::TS_W-1:0]            o_trade_time,
    output logic                                 o_status,
    output logic [lobm_pkg::FILL_W-1:0]          o_fill_count,
    output logic signed [lobm_pkg::HINT_W-1:0]   o_best_bid,
    output logic signed [lobm_pkg::HINT_W-1:0]   o_best_ask,
    output logic [lobm_pkg::CNT_W-1:0]           o_resting_count
);

    lobm_pkg::t_pool_cmd  pool_cmd;
    lobm_pkg::t_pool_stat pool_stat;

    lobm_slot_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pool_cmd),
        .o_stat  (pool_stat)
    );

    lobm_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_order_id       (i_order_id),
        .i_side           (i_side),
        .i_price          (i_price),
        .i_quantity       (i_quantity),
        .i_timestamp      (i_timestamp),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_last           (o_last),
        .o_buy_id         (o_buy_id),
        .o_sell_id        (o_sell_id),
        .o_trade_price    (o_trade_price),
        .o_trade_quantity (o_trade_quantity),
        .o_trade_time     (o_trade_time),
        .o_status         (o_status),
        .o_fill_count     (o_fill_count),
        .o_best_bid       (o_best_bid),
        .o_best_ask       (o_best_ask),
        .o_resting_count  (o_resting_count),
        .o_pool_cmd       (pool_cmd),
        .i_pool_stat      (pool_stat)
    );

endmodule

/* design/lobm_checker.sv */
// lobm_checker: port-level assertions on the order book matcher, and its bind.
// Depends on lobm_pkg and limit_order_book_matcher_unit.
module lobm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_last,
    input logic [lobm_pkg::ORDER_ID_BITS-1:0]   o_buy_id,
    input logic [lobm_pkg::QTY_W-1:0]           o_trade_quantity,
    input logic [lobm_pkg::TS_W-1:0]            o_trade_time,
    input logic                                 o_status,
    input logic [lobm_pkg::FILL_W-1:0]          o_fill_count,
    input logic signed [lobm_pkg::HINT_W-1:0]   o_best_bid,
    input logic signed [lobm_pkg::HINT_W-1:0]   o_best_ask,
    input logic [lobm_pkg::CNT_W-1:0]           o_resting_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_trade_time))
        else $error("result changed while stalled");

    a_final_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_trade_quantity == '0 && o_buy_id == '0)
        else $error("final item carries trade fields");

    a_trade_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_status && o_fill_count == '0 &&
                                   o_resting_count == '0)
        else $error("trade item carries status fields");

    a_book_uncrossed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && o_best_bid >= 0 && o_best_ask >= 0 |->
            o_best_bid < o_best_ask)
        else $error("book crossed");

    a_rest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_resting_count <= lobm_pkg::CNT_W'(lobm_pkg::ORDER_SLOTS))
        else $error("resting count out of range");

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_last           (o_last),
    .o_buy_id         (o_buy_id),
    .o_trade_quantity (o_trade_quantity),
    .o_trade_time     (o_trade_time),
    .o_status         (o_status),
    .o_fill_count     (o_fill_count),
    .o_best_bid       (o_best_bid),
    .o_best_ask       (o_best_ask),
    .o_resting_count  (o_resting_count)
);

/* sim/tb.sv */
// tb: self-checking testbench for limit_order_book_matcher_unit.
// Holds its own model of the order book, predicts the trades and the status of each
// transaction, and checks every result. Depends on lobm_pkg and the unit.
module tb;

    localparam int NONE = 127;

    typedef struct packed {
        bit        last;
        bit [15:0] buy_id;
        bit [15:0] sell_id;
        bit [9:0]  price;
        bit [31:0] qty;
        bit [63:0] stamp;
        bit        status;
        bit [5:0]  fills;
        bit [10:0] bid;
        bit [10:0] ask;
        bit [6:0]  resting;
    } t_book_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = 0;
    logic [15:0] i_order_id = 0;
    logic        i_side = 0;
    logic [9:0]  i_price = 0;
    logic [31:0] i_quantity = 0;
    logic [63:0] i_timestamp = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic        o_last;
    logic [15:0] o_buy_id, o_sell_id;
    logic [9:0]  o_trade_price;
    logic [31:0] o_trade_quantity;
    logic [63:0] o_trade_time;
    logic        o_status;
    logic [5:0]  o_fill_count;
    logic signed [10:0] o_best_bid, o_best_ask;
    logic [6:0]  o_resting_count;

    limit_order_book_matcher_unit uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // book model
    int        slot_oid[64], slot_px[64], slot_nx[64], slot_pv[64];
    bit [31:0] slot_left[64];
    bit        slot_sd[64], slot_open[64];
    int        lvl_head[2][1024], lvl_tail[2][1024];
    int        id_slot[65536];
    int        best_bid, best_ask, resting;

    t_book_result trades_due[$];
    int  mismatches = 0;
    bit  quiet_send = 0;
    bit  quiet_recv = 0;
    bit  hold_request = 0;
    int  hold_left = 0;
    int  known_ids[$];

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void level_append(bit sd, int p, int s);
        slot_nx[s] = NONE;
        slot_pv[s] = lvl_tail[sd][p];
        if (lvl_tail[sd][p] != NONE) slot_nx[lvl_tail[sd][p]] = s;
        else lvl_head[sd][p] = s;
        lvl_tail[sd][p] = s;
    endfunction

    function automatic void level_remove(bit sd, int p, int s);
        int pv, nx;
        pv = slot_pv[s];
        nx = slot_nx[s];
        if (pv != NONE) slot_nx[pv] = nx; else lvl_head[sd][p] = nx;
        if (nx != NONE) slot_pv[nx] = pv; else lvl_tail[sd][p] = pv;
    endfunction

    function automatic void book_clear();
        for (int i = 0; i < 64; i++) slot_open[i] = 1;
        for (int p = 0; p < 1024; p++) begin
            lvl_head[0][p] = NONE; lvl_tail[0][p] = NONE;
            lvl_head[1][p] = NONE; lvl_tail[1][p] = NONE;
        end
        for (int i = 0; i < 65536; i++) id_slot[i] = NONE;
        best_bid = -1;
        best_ask = -1;
        resting = 0;
    endfunction

    function automatic void book_match(bit [1:0] cmd, bit [15:0] oid, bit sd, bit [9:0] px,
                                       bit [31:0] qty, bit [63:0] ts);
        int s, c, lp, cur, nxt, fills, other;
        bit [31:0] rem, f;
        bit st, lim;
        bit osd;
        t_book_result r;
        s = NONE; rem = qty; lim = (cmd == lobm_pkg::CMD_LIMIT); fills = 0; st = 0; osd = ~sd;
        for (int i = 0; i < 64; i++)
            if (s == NONE && slot_open[i]) begin
                s = i;
                slot_open[i] = 0;
            end
        if (s == NONE) begin
            st = 1;
        end else if (cmd == lobm_pkg::CMD_CANCEL || cmd == lobm_pkg::CMD_CANCEL_ALT) begin
            slot_open[s] = 1;
            c = id_slot[oid];
            if (c == NONE) begin
                st = 1;
            end else begin
                level_remove(slot_sd[c], slot_px[c], c);
                id_slot[oid] = NONE;
                slot_open[c] = 1;
                resting--;
            end
        end else begin
            while (rem != 0) begin
                lp = sd ? best_bid : best_ask;
                if (lp < 0) break;
                if (lim && (sd ? int'(px) > lp : int'(px) < lp)) break;
                cur = lvl_head[osd][lp];
                while (cur != NONE && rem != 0) begin
                    f = (rem < slot_left[cur]) ? rem : slot_left[cur];
                    other = slot_oid[cur];
                    r = '0;
                    r.buy_id = sd ? other[15:0] : oid;
                    r.sell_id = sd ? oid : other[15:0];
                    r.price = lp[9:0];
                    r.qty = f;
                    r.stamp = ts;
                    trades_due.push_back(r);
                    fills++;
                    rem -= f;
                    slot_left[cur] -= f;
                    if (slot_left[cur] == 0) begin
                        nxt = slot_nx[cur];
                        level_remove(osd, lp, cur);
                        if (id_slot[other] == cur) id_slot[other] = NONE;
                        slot_open[cur] = 1;
                        resting--;
                        cur = nxt;
                    end else begin
                        break;
                    end
                end
                if (lvl_head[osd][lp] == NONE) begin
                    if (sd) best_bid = lp > 0 ? lp - 1 : -1;
                    else best_ask = lp < 1023 ? lp + 1 : -1;
                end
            end
            if (lim && rem != 0) begin
                slot_oid[s] = oid;
                slot_px[s] = px;
                slot_left[s] = rem;
                slot_sd[s] = sd;
                level_append(sd, px, s);
                if (sd) begin
                    if (best_ask < 0 || int'(px) < best_ask) best_ask = px;
                end else begin
                    if (best_bid < 0 || int'(px) > best_bid) best_bid = px;
                end
                id_slot[oid] = s;
                resting++;
            end else begin
                slot_open[s] = 1;
            end
        end
        if (best_bid >= 0) begin
            lp = best_bid;
            while (lp >= 0 && lvl_head[0][lp] == NONE) lp--;
            best_bid = lp;
        end
        if (best_ask >= 0) begin
            lp = best_ask;
            while (lp < 1024 && lvl_head[1][lp] == NONE) lp++;
            best_ask = (lp == 1024) ? -1 : lp;
        end
        r = '0;
        r.last = 1;
        r.status = st;
        r.fills = fills[5:0];
        r.bid = best_bid[10:0];
        r.ask = best_ask[10:0];
        r.resting = resting[6:0];
        trades_due.push_back(r);
    endfunction

    task automatic send_order(bit [1:0] cmd, bit [15:0] oid, bit sd, bit [9:0] px,
                              bit [31:0] qty, bit [63:0] ts);
        int gap;
        gap = pick_gap(quiet_send);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_order_id <= oid;
        i_side <= sd;
        i_price <= px;
        i_quantity <= qty;
        i_timestamp <= ts;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        book_match(cmd, oid, sd, px, qty, ts);
        if (cmd == lobm_pkg::CMD_LIMIT) begin
            known_ids.push_back(oid);
            if (known_ids.size() > 80) void'(known_ids.pop_front());
        end
    endtask

    task automatic send_random();
        int k, r;
        bit [15:0] oid;
        bit [9:0] px;
        bit [31:0] qty;
        bit [1:0] cmd;
        k = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        if (r < 70) oid = 16'($urandom_range(0, 200));
        else oid = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 75) px = 10'(496 + $urandom_range(0, 32));
        else if (r < 85) px = 10'($urandom_range(0, 1023));
        else px = r[0] ? 10'd0 : 10'd1023;
        r = $urandom_range(0, 99);
        if (r < 85) qty = $urandom_range(1, 100);
        else if (r < 90) qty = 0;
        else qty = $urandom;
        if (resting > 44) k = k / 2 + 50;
        if (k < 55) cmd = lobm_pkg::CMD_LIMIT;
        else if (k < 72) cmd = lobm_pkg::CMD_MARKET;
        else cmd = (k < 95) ? lobm_pkg::CMD_CANCEL : lobm_pkg::CMD_CANCEL_ALT;
        if (cmd[1] && known_ids.size() > 0 && $urandom_range(0, 3) != 0)
            oid = 16'(known_ids[$urandom_range(0, known_ids.size() - 1)]);
        send_order(cmd, oid, 1'($urandom_range(0, 1)), px, qty, {$urandom, $urandom});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_request) begin
            hold_request = 0;
            hold_left = 600;
            i_out_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 0;
        end else if (quiet_recv) begin
            i_out_ready <= 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) == 0 ? 0 : 1)
                           && $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge i_clk) begin
        t_book_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_last, o_buy_id, o_sell_id, o_trade_price, o_trade_quantity, o_trade_time,
                   o_status, o_fill_count, o_best_bid, o_best_ask, o_resting_count};
            if (trades_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %h", got);
            end else begin
                want = trades_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch last %0d/%0d buy %0d/%0d sell %0d/%0d px %0d/%0d",
                                 want.last, got.last, want.buy_id, got.buy_id,
                                 want.sell_id, got.sell_id, want.price, got.price,
                                 " qty %0d/%0d ts %h/%h st %0d/%0d fc %0d/%0d",
                                 want.qty, got.qty, want.stamp, got.stamp,
                                 want.status, got.status, want.fills, got.fills,
                                 " bid %0d/%0d ask %0d/%0d rest %0d/%0d",
                                 $signed(want.bid), $signed(got.bid),
                                 $signed(want.ask), $signed(got.ask),
                                 want.resting, got.resting);
                end
            end
        end
    end

    task automatic test_directed();
        send_order(lobm_pkg::CMD_LIMIT, 16'd1, lobm_pkg::SIDE_BUY, 10'd0, 32'd5, 64'd1);
        send_order(lobm_pkg::CMD_LIMIT, 16'd2, lobm_pkg::SIDE_SELL, 10'd1023, 32'hFFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF);
        send_order(lobm_pkg::CMD_LIMIT, 16'hFFFF, lobm_pkg::SIDE_BUY, 10'd500, 32'd10, 64'd2);
        send_order(lobm_pkg::CMD_LIMIT, 16'd4, lobm_pkg::SIDE_BUY, 10'd500, 32'd10, 64'd3);
        send_order(lobm_pkg::CMD_LIMIT, 16'd5, lobm_pkg::SIDE_SELL, 10'd490, 32'd15, 64'd4);
        send_order(lobm_pkg::CMD_LIMIT, 16'd6, lobm_pkg::SIDE_SELL, 10'd510, 32'd7, 64'd5);
        send_order(lobm_pkg::CMD_MARKET, 16'd7, lobm_pkg::SIDE_BUY, 10'd0, 32'd3, 64'd6);
        send_order(lobm_pkg::CMD_MARKET, 16'd8, lobm_pkg::SIDE_SELL, 10'd0, 32'd100, 64'd7);
        send_order(lobm_pkg::CMD_LIMIT, 16'd9, lobm_pkg::SIDE_BUY, 10'd0, 32'd0, 64'd8);
        send_order(lobm_pkg::CMD_CANCEL, 16'd1234, lobm_pkg::SIDE_BUY, 10'd0, 32'd0, 64'd9);
        send_order(lobm_pkg::CMD_LIMIT, 16'd20, lobm_pkg::SIDE_BUY, 10'd300, 32'd4, 64'd10);
        send_order(lobm_pkg::CMD_LIMIT, 16'd20, lobm_pkg::SIDE_BUY, 10'd301, 32'd4, 64'd11);
        send_order(lobm_pkg::CMD_CANCEL, 16'd20, lobm_pkg::SIDE_SELL, 10'd0, 32'd0, 64'd12);
        send_order(lobm_pkg::CMD_CANCEL_ALT, 16'd20, lobm_pkg::SIDE_BUY, 10'd0, 32'd0, 64'd13);
        send_order(lobm_pkg::CMD_LIMIT, 16'd20, lobm_pkg::SIDE_SELL, 10'd300, 32'd2, 64'd14);
        send_order(lobm_pkg::CMD_CANCEL, 16'd2, lobm_pkg::SIDE_BUY, 10'd0, 32'd0, 64'd15);
        send_order(lobm_pkg::CMD_LIMIT, 16'd30, lobm_pkg::SIDE_SELL, 10'd1023, 32'd1, 64'd16);
        send_order(lobm_pkg::CMD_MARKET, 16'd31, lobm_pkg::SIDE_BUY, 10'd1023, 32'hFFFF_FFFF,
                   64'd17);
        send_order(lobm_pkg::CMD_MARKET, 16'd32, lobm_pkg::SIDE_SELL, 10'd5, 32'hFFFF_FFFF,
                   64'd18);
        send_order(lobm_pkg::CMD_MARKET, 16'd33, lobm_pkg::SIDE_SELL, 10'd5, 32'd1, 64'd19);
    endtask

    task automatic test_backpressure();
        quiet_send = 1;
        hold_request = 1;
        repeat (60) send_random();
        quiet_send = 0;
    endtask

    task automatic test_random();
        for (int n = 0; n < 340; n++) begin
            if (n == 150) begin
                quiet_send = 1;
                quiet_recv = 1;
            end
            if (n == 200) begin
                quiet_send = 0;
                quiet_recv = 0;
            end
            send_random();
        end
    endtask

    task automatic test_pool_full();
        while (resting < 64) begin
            if (best_ask != 0)
                send_order(lobm_pkg::CMD_LIMIT, 16'($urandom), lobm_pkg::SIDE_BUY, 10'd0,
                           32'd3, 64'd50);
            else
                send_order(lobm_pkg::CMD_LIMIT, 16'($urandom), lobm_pkg::SIDE_SELL, 10'd1023,
                           32'd3, 64'd51);
        end
        send_order(lobm_pkg::CMD_CANCEL, 16'(known_ids[known_ids.size() - 1]),
                   lobm_pkg::SIDE_BUY, 10'd0, 32'd0, 64'd52);
        send_order(lobm_pkg::CMD_MARKET, 16'd77, lobm_pkg::SIDE_SELL, 10'd0, 32'd10, 64'd53);
        send_order(lobm_pkg::CMD_LIMIT, 16'd78, lobm_pkg::SIDE_BUY, 10'd1023, 32'd10, 64'd54);
    endtask

    initial begin
        book_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_backpressure();
        test_random();
        test_pool_full();
        i_in_valid <= 0;
        while (trades_due.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #240_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
